// ----- rtl/ovsp_pkg.sv -----
package ovsp_pkg;

  localparam int MAX_LEVELS_DEF = 5;

  localparam int REQ_W   = 2;
  localparam int LEVEL_W = 3;
  localparam int COORD_W = 5;
  localparam int STATE_W = 2;
  localparam int STAT_W  = 2;
  localparam int GRID_W  = 3;

  localparam logic [GRID_W-1:0] GRID_LEVELS_RST = 3'd5;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_t;

  typedef enum logic [STATE_W-1:0] {
    NS_EMPTY = 2'd0,
    NS_SOLID = 2'd1,
    NS_MIXED = 2'd2
  } node_state_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_UNBUILT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_VOX  = 2'd1,
    SRC_NODE = 2'd2
  } rd_src_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_BUILD  = 2'd1,
    S_BDRAIN = 2'd2
  } bld_state_t;

endpackage

// ----- rtl/ovsp_ifs.sv -----
interface ovsp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ovsp_pkg::REQ_W-1:0]   req_type;
  logic [ovsp_pkg::LEVEL_W-1:0] level;
  logic [ovsp_pkg::COORD_W-1:0] coord_x;
  logic [ovsp_pkg::COORD_W-1:0] coord_y;
  logic [ovsp_pkg::COORD_W-1:0] coord_z;
  logic                         voxel_solid;

  modport source (output valid, req_type, level, coord_x, coord_y, coord_z, voxel_solid,
                  input ready);
  modport sink   (input valid, req_type, level, coord_x, coord_y, coord_z, voxel_solid,
                  output ready);
endinterface

interface ovsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [ovsp_pkg::STATE_W-1:0] node_state;
  logic [ovsp_pkg::STAT_W-1:0]  status;

  modport source (output valid, node_state, status, input ready);
  modport sink   (input valid, node_state, status, output ready);
endinterface

interface ovsp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ovsp_pkg::GRID_W-1:0] grid_levels;

  modport source (output valid, grid_levels, input ready);
  modport sink   (input valid, grid_levels, output ready);
endinterface

// ----- rtl/octree_voxel_state_pyramid_top.sv -----
// Voxel occupancy pyramid. Load transactions write one occupancy bit per voxel into a
// voxel memory; a build transaction reduces the grid bottom-up into a complete octree of
// EMPTY / SOLID / MIXED nodes held in a node memory; query transactions read one node back
// by level and coordinates (leaf-level queries read the voxel memory directly). Every
// transaction returns exactly one result. Loads, queries and unknown requests are accepted
// at a sustained rate of one per cycle while no build runs and the output does not stall;
// each result passes the result stage and then the output register. A build walks every
// internal node, reading its eight children one per cycle while no result is pending,
// through the single read port of the voxel or node memory; it holds the block until the
// whole pyramid is written, and its result appears then. Both memories come up undefined
// and need no clearing pass. The grid_levels register may be written at any time the block
// is idle; it clears the built flag.
module octree_voxel_state_pyramid_top #(
  parameter int MAX_LEVELS = ovsp_pkg::MAX_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ovsp_in_if.sink    in_if,
  ovsp_out_if.source out_if,
  ovsp_cfg_if.sink   cfg_if
);
  import ovsp_pkg::*;

  localparam int LW         = $clog2(MAX_LEVELS + 1);
  localparam int VAW        = 3 * MAX_LEVELS;
  localparam int VOX_DEPTH  = 1 << VAW;
  localparam int NODE_COUNT = ((1 << (3 * (MAX_LEVELS + 1))) - 1) / 7;
  localparam int NAW        = $clog2(NODE_COUNT);
  localparam logic [2:0] CHILD_LAST = 3'd7;

  // Voxel index: fixed stride of MAX_LEVELS bits per axis.
  function automatic logic [VAW-1:0] vox_idx(input logic [MAX_LEVELS-1:0] x,
                                             input logic [MAX_LEVELS-1:0] y,
                                             input logic [MAX_LEVELS-1:0] z);
    return {z, y, x};
  endfunction

  // Node index: level base (octal 11..1 pattern) plus packed coordinates at that level.
  function automatic logic [NAW-1:0] node_idx(input logic [LW-1:0]         l,
                                               input logic [MAX_LEVELS-1:0] x,
                                               input logic [MAX_LEVELS-1:0] y,
                                               input logic [MAX_LEVELS-1:0] z);
    logic [NAW-1:0] base;
    base = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (k < int'(l)) base[3*k] = 1'b1;
    end
    return base + NAW'(x) + (NAW'(y) << l) + (NAW'(z) << {l, 1'b0});
  endfunction

  // Memories
  logic                   vox_mem [VOX_DEPTH];
  logic [STATE_W-1:0]     node_mem [NODE_COUNT];

  logic                   vox_we, vox_re, vox_wd, vox_rd_r;
  logic [VAW-1:0]         vox_wa, vox_ra;
  logic                   node_we, node_re;
  logic [NAW-1:0]         node_wa, node_ra;
  logic [STATE_W-1:0]     node_wd, node_rd_r;

  // Control
  bld_state_t             state_r, state_nxt;
  logic [GRID_W-1:0]      grid_levels_r;
  logic                   built_r, built_nxt;
  logic [LW-1:0]          lv;
  logic                   in_acc, cfg_acc, out_free, s1_adv;

  // Result stage ahead of the output register
  logic                   s1_valid_r, s1_valid_nxt;
  rd_src_t                s1_src_r, s1_src_nxt;
  status_t                s1_status_r, s1_status_nxt;

  logic                   out_valid_r;
  logic [STATE_W-1:0]     out_state_r;
  logic [STAT_W-1:0]      out_status_r;

  // Build walk counters
  logic [LW-1:0]          bpl_r, bpl_nxt;
  logic [MAX_LEVELS-1:0]  bx_r, by_r, bz_r, bx_nxt, by_nxt, bz_nxt;
  logic [2:0]             bc_r, bc_nxt;
  logic [MAX_LEVELS-1:0]  side_m1, cx, cy, cz;
  logic [LW-1:0]          cl;

  // Child read pipeline
  logic                   rd_v_r, rd_v_nxt;
  logic                   rd_vox_r, rd_vox_nxt;
  logic                   rd_first_r, rd_first_nxt;
  logic                   rd_last_r, rd_last_nxt;
  logic [NAW-1:0]         rd_pa_r, rd_pa_nxt;
  logic [STATE_W-1:0]     cs;
  logic                   acc_s_r, acc_e_r, acc_m_r, acc_s, acc_e, acc_m;

  logic [MAX_LEVELS-1:0]  qx, qy, qz;
  logic                   ld_oob, q_oob;

  assign lv = ({1'b0, grid_levels_r} > (GRID_W + 1)'(MAX_LEVELS)) ?
              LW'(MAX_LEVELS) : LW'(grid_levels_r);

  assign out_free     = !out_valid_r || out_if.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_if.ready  = (state_r == S_IDLE) && (!s1_valid_r || out_free);
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid && cfg_if.ready;

  assign qx = MAX_LEVELS'(in_if.coord_x);
  assign qy = MAX_LEVELS'(in_if.coord_y);
  assign qz = MAX_LEVELS'(in_if.coord_z);

  assign ld_oob = ((in_if.coord_x >> lv) != '0) || ((in_if.coord_y >> lv) != '0) ||
                  ((in_if.coord_z >> lv) != '0);
  assign q_oob  = (4'(in_if.level) > 4'(lv)) ||
                  ((in_if.coord_x >> in_if.level) != '0) ||
                  ((in_if.coord_y >> in_if.level) != '0) ||
                  ((in_if.coord_z >> in_if.level) != '0);

  // Child addresses of the current parent; child level is one below the parent.
  assign side_m1 = MAX_LEVELS'((1 << bpl_r) - 1);
  assign cx      = MAX_LEVELS'({bx_r, bc_r[0]});
  assign cy      = MAX_LEVELS'({by_r, bc_r[1]});
  assign cz      = MAX_LEVELS'({bz_r, bc_r[2]});
  assign cl      = bpl_r + LW'(1);

  // Fold each returning child into the running flags; write the parent on the eighth.
  always_comb begin
    logic cur_s, cur_e;
    cs    = rd_vox_r ? {1'b0, vox_rd_r} : node_rd_r;
    cur_s = (cs == NS_SOLID);
    cur_e = (cs == NS_EMPTY);
    acc_s = cur_s || (!rd_first_r && acc_s_r);
    acc_e = cur_e || (!rd_first_r && acc_e_r);
    acc_m = (!cur_s && !cur_e) || (!rd_first_r && acc_m_r);
    node_we = rd_v_r && rd_last_r;
    node_wa = rd_pa_r;
    if (acc_m || (acc_s && acc_e)) begin
      node_wd = NS_MIXED;
    end else if (acc_s) begin
      node_wd = NS_SOLID;
    end else begin
      node_wd = NS_EMPTY;
    end
  end

  // Next state and memory port control
  always_comb begin
    state_nxt     = state_r;
    built_nxt     = built_r;
    s1_valid_nxt  = s1_adv ? 1'b0 : s1_valid_r;
    s1_src_nxt    = s1_src_r;
    s1_status_nxt = s1_status_r;
    bpl_nxt       = bpl_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    bz_nxt        = bz_r;
    bc_nxt        = bc_r;
    rd_v_nxt      = 1'b0;
    rd_vox_nxt    = rd_vox_r;
    rd_first_nxt  = rd_first_r;
    rd_last_nxt   = rd_last_r;
    rd_pa_nxt     = rd_pa_r;
    vox_we        = 1'b0;
    vox_wa        = vox_idx(qx, qy, qz);
    vox_wd        = in_if.voxel_solid;
    vox_re        = 1'b0;
    vox_ra        = vox_idx(qx, qy, qz);
    node_re       = 1'b0;
    node_ra       = node_idx(LW'(in_if.level), qx, qy, qz);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          s1_valid_nxt  = 1'b1;
          s1_src_nxt    = SRC_NONE;
          s1_status_nxt = ST_OK;
          case (req_type_t'(in_if.req_type))
            REQ_LOAD: begin
              if (ld_oob) begin
                s1_status_nxt = ST_RANGE;
              end else begin
                vox_we    = 1'b1;
                built_nxt = 1'b0;
              end
            end
            REQ_BUILD: begin
              // Result is issued once the walk completes.
              s1_valid_nxt = 1'b0;
              bpl_nxt      = lv - LW'(1);
              bx_nxt       = '0;
              by_nxt       = '0;
              bz_nxt       = '0;
              bc_nxt       = '0;
              state_nxt    = (lv == '0) ? S_BDRAIN : S_BUILD;
            end
            REQ_QUERY: begin
              if (!built_r) begin
                s1_status_nxt = ST_UNBUILT;
              end else if (q_oob) begin
                s1_status_nxt = ST_RANGE;
              end else if (4'(in_if.level) == 4'(lv)) begin
                vox_re     = 1'b1;
                s1_src_nxt = SRC_VOX;
              end else begin
                node_re    = 1'b1;
                s1_src_nxt = SRC_NODE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_BUILD: begin
        // Hold the walk until a pending query result has left the read registers.
        if (!s1_valid_r) begin
          rd_v_nxt     = 1'b1;
          rd_first_nxt = (bc_r == '0);
          rd_last_nxt  = (bc_r == CHILD_LAST);
          rd_pa_nxt    = node_idx(bpl_r, bx_r, by_r, bz_r);
          if (cl == lv) begin
            vox_re     = 1'b1;
            vox_ra     = vox_idx(cx, cy, cz);
            rd_vox_nxt = 1'b1;
          end else begin
            node_re    = 1'b1;
            node_ra    = node_idx(cl, cx, cy, cz);
            rd_vox_nxt = 1'b0;
          end
          bc_nxt = bc_r + 3'd1;
          if (bc_r == CHILD_LAST) begin
            bx_nxt = bx_r + MAX_LEVELS'(1);
            if (bx_r == side_m1) begin
              bx_nxt = '0;
              by_nxt = by_r + MAX_LEVELS'(1);
              if (by_r == side_m1) begin
                by_nxt = '0;
                bz_nxt = bz_r + MAX_LEVELS'(1);
                if (bz_r == side_m1) begin
                  bz_nxt = '0;
                  if (bpl_r == '0) begin
                    state_nxt = S_BDRAIN;
                  end else begin
                    bpl_nxt = bpl_r - LW'(1);
                  end
                end
              end
            end
          end
        end
      end

      S_BDRAIN: begin
        // Wait for the root write, then post the build result.
        if (!rd_v_r && !s1_valid_r) begin
          built_nxt     = 1'b1;
          s1_valid_nxt  = 1'b1;
          s1_src_nxt    = SRC_NONE;
          s1_status_nxt = ST_OK;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (cfg_acc) built_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (vox_we) vox_mem[vox_wa] <= vox_wd;
    if (vox_re) vox_rd_r <= vox_mem[vox_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) node_rd_r <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      grid_levels_r <= GRID_LEVELS_RST;
      built_r       <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      rd_v_r        <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      built_r    <= built_nxt;
      s1_valid_r <= s1_valid_nxt;
      rd_v_r     <= rd_v_nxt;
      if (cfg_acc) grid_levels_r <= cfg_if.grid_levels;
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_src_r    <= s1_src_nxt;
    s1_status_r <= s1_status_nxt;
    bpl_r       <= bpl_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    bz_r        <= bz_nxt;
    bc_r        <= bc_nxt;
    rd_vox_r    <= rd_vox_nxt;
    rd_first_r  <= rd_first_nxt;
    rd_last_r   <= rd_last_nxt;
    rd_pa_r     <= rd_pa_nxt;
    if (rd_v_r) begin
      acc_s_r <= acc_s;
      acc_e_r <= acc_e;
      acc_m_r <= acc_m;
    end
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      case (s1_src_r)
        SRC_VOX:  out_state_r <= {1'b0, vox_rd_r};
        SRC_NODE: out_state_r <= node_rd_r;
        default:  out_state_r <= NS_EMPTY;
      endcase
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.node_state = out_state_r;
  assign out_if.status     = out_status_r;

  // Build reads never share the read registers with a pending query result.
  a_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> !s1_valid_r)
    else $error("build read overlaps pending result");

  // Node memory is written only by the build walk.
  a_node_we: assert property (@(posedge clk) disable iff (!rst_n)
    node_we |-> (state_r == S_BUILD || state_r == S_BDRAIN))
    else $error("node write outside build");

  // A register write always invalidates the pyramid.
  a_cfg_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !built_r)
    else $error("built flag survived config write");

  // End of build marks the pyramid built and posts its result.
  a_bld_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BDRAIN && !rd_v_r && !s1_valid_r && !cfg_acc) |=>
      (built_r && s1_valid_r && state_r == S_IDLE))
    else $error("build did not complete");

endmodule

// ----- bench/tb_octree_voxel_state_pyramid_top.sv -----
`timescale 1ns / 100ps

module tb_octree_voxel_state_pyramid_top;
  import ovsp_pkg::*;

  localparam int MAXL         = MAX_LEVELS_DEF;
  localparam int VOX_SLOTS    = 1 << (3 * MAXL);
  localparam int NODE_SLOTS   = ((1 << (3 * (MAXL + 1))) - 1) / 7;
  // Settling time after the last reply, before a register write.
  localparam int DRAIN_CYCLES = 8;
  // A full-depth build runs with no transaction on any channel.
  localparam int QUIET_LIMIT  = 160000;
  localparam int LONG_STALL   = 400;
  localparam int REGIONS      = 512;

  // Request code outside the defined set; the block answers it with a zero result.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    FILL_EMPTY = 2'd0,
    FILL_SOLID = 2'd1,
    FILL_NOISE = 2'd2
  } fill_mode_t;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [LEVEL_W-1:0] lvl;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               solid;
  } voxel_req_t;

  typedef struct {
    node_state_t state;
    status_t     status;
  } node_reply_t;

  logic clk;
  logic rst_n;

  ovsp_in_if  in_bus ();
  ovsp_out_if out_bus ();
  ovsp_cfg_if cfg_bus ();

  octree_voxel_state_pyramid_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  // Requests waiting to be offered, and replies the block still owes us.
  voxel_req_t  req_backlog[$];
  node_reply_t awaited_replies[$];

  // Shadow of the block: voxel image, classified tree, built flag, register copy.
  bit                voxel_image [VOX_SLOTS];
  node_state_t       tree_states [NODE_SLOTS];
  bit                tree_valid  = 1'b0;
  logic [GRID_W-1:0] grid_shadow = GRID_LEVELS_RST;

  // Stimulus-side bookkeeping: which voxels have been written, and the fill pattern.
  bit         seeded [VOX_SLOTS];
  fill_mode_t region_mode [REGIONS];
  int         grain;
  int         plan_levels;
  int         phase_no = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int long_stall_req = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  bit in_fire        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_depth();
    return (grid_shadow > MAXL) ? MAXL : grid_shadow;
  endfunction

  function automatic int unsigned vox_addr(input int unsigned x, y, z);
    return x + (y << MAXL) + (z << (2 * MAXL));
  endfunction

  // Nodes of a level sit after all shallower levels, x fastest.
  function automatic int unsigned tree_slot(input int unsigned l, x, y, z);
    return ((1 << (3 * l)) - 1) / 7 + x + (y << l) + (z << (2 * l));
  endfunction

  // Copy leaves from the voxel image, then fold each octet of children into its parent.
  function automatic void rebuild_tree();
    int unsigned lv, side, l, ps, x, y, z, c;
    bit          any_s, any_e, any_m;
    node_state_t s;
    lv   = eff_depth();
    side = 1 << lv;
    for (z = 0; z < side; z++)
      for (y = 0; y < side; y++)
        for (x = 0; x < side; x++)
          tree_states[tree_slot(lv, x, y, z)] =
            voxel_image[vox_addr(x, y, z)] ? NS_SOLID : NS_EMPTY;
    for (l = lv; l > 0; l--) begin
      ps = 1 << (l - 1);
      for (z = 0; z < ps; z++)
        for (y = 0; y < ps; y++)
          for (x = 0; x < ps; x++) begin
            any_s = 1'b0;
            any_e = 1'b0;
            any_m = 1'b0;
            for (c = 0; c < 8; c++) begin
              s = tree_states[tree_slot(l, 2 * x + (c & 1), 2 * y + ((c >> 1) & 1),
                                        2 * z + ((c >> 2) & 1))];
              case (s)
                NS_SOLID: any_s = 1'b1;
                NS_EMPTY: any_e = 1'b1;
                default:  any_m = 1'b1;
              endcase
            end
            tree_states[tree_slot(l - 1, x, y, z)] =
              (any_m || (any_s && any_e)) ? NS_MIXED : (any_s ? NS_SOLID : NS_EMPTY);
          end
    end
    tree_valid = 1'b1;
  endfunction

  // Advance the shadow by one request and return the reply it must produce.
  function automatic node_reply_t apply_request(input voxel_req_t r);
    node_reply_t rep;
    int unsigned lv, side, lvl;
    rep.state  = NS_EMPTY;
    rep.status = ST_OK;
    lv         = eff_depth();
    case (r.req)
      REQ_LOAD: begin
        side = 1 << lv;
        if (r.x >= side || r.y >= side || r.z >= side) begin
          rep.status = ST_RANGE;
        end else begin
          voxel_image[vox_addr(r.x, r.y, r.z)] = r.solid;
          tree_valid = 1'b0;
        end
      end
      REQ_BUILD: rebuild_tree();
      REQ_QUERY: begin
        lvl  = r.lvl;
        side = 1 << lvl;
        // The built check wins over the range check.
        if (!tree_valid) begin
          rep.status = ST_UNBUILT;
        end else if (lvl > lv || r.x >= side || r.y >= side || r.z >= side) begin
          rep.status = ST_RANGE;
        end else begin
          rep.state = tree_states[tree_slot(lvl, r.x, r.y, r.z)];
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // Queue one request; remember which voxels an in-range load writes.
  task automatic queue_req(input logic [REQ_W-1:0] req, input int lvl, x, y, z, solid);
    voxel_req_t r;
    int         side;
    r.req   = req;
    r.lvl   = LEVEL_W'(lvl);
    r.x     = COORD_W'(x);
    r.y     = COORD_W'(y);
    r.z     = COORD_W'(z);
    r.solid = solid[0];
    side    = 1 << plan_levels;
    if (req == REQ_LOAD && x < side && y < side && z < side)
      seeded[vox_addr(x, y, z)] = 1'b1;
    req_backlog.push_back(r);
  endtask

  function automatic int pattern_bit(input int x, y, z);
    int key;
    key = ((x >> grain) & 7) | (((y >> grain) & 7) << 3) | (((z >> grain) & 7) << 6);
    case (region_mode[key])
      FILL_EMPTY: return 0;
      FILL_SOLID: return 1;
      default:    return $urandom_range(1);
    endcase
  endfunction

  // Write the cube in use with a blocky pattern so every level sees uniform and mixed
  // nodes. Unless asked to rewrite all of it, write only voxels never written.
  task automatic load_cube(input bit full);
    int         side, i, x, y, z, pick;
    bit         uniform;
    fill_mode_t m;
    side    = 1 << plan_levels;
    grain   = $urandom_range(plan_levels);
    uniform = ($urandom_range(5) == 0);
    for (i = 0; i < REGIONS; i++) begin
      if (i == 0 || !uniform) begin
        pick = $urandom_range(9);
        m    = (pick < 4) ? FILL_EMPTY : ((pick < 8) ? FILL_SOLID : FILL_NOISE);
      end
      region_mode[i] = m;
    end
    for (z = 0; z < side; z++)
      for (y = 0; y < side; y++)
        for (x = 0; x < side; x++)
          if (full || !seeded[vox_addr(x, y, z)])
            queue_req(REQ_LOAD, $urandom_range(7), x, y, z, pattern_bit(x, y, z));
  endtask

  // One well-formed pass: load, touch a few voxels, maybe query the unbuilt tree, build, then
  // mostly valid queries mixed with range errors, unknown requests and rejected loads.
  task automatic run_round(input int nq, input bit full);
    int side, pick, lvl, axis;
    int c [3];
    side = 1 << plan_levels;
    load_cube(full);
    repeat ($urandom_range(1, 6))
      queue_req(REQ_LOAD, $urandom_range(7), $urandom_range(side - 1),
                $urandom_range(side - 1), $urandom_range(side - 1), $urandom_range(1));
    if ($urandom_range(1))
      queue_req(REQ_QUERY, $urandom_range(7), $urandom_range(31), $urandom_range(31),
                $urandom_range(31), $urandom_range(1));
    queue_req(REQ_BUILD, $urandom_range(7), $urandom_range(31), $urandom_range(31),
              $urandom_range(31), $urandom_range(1));
    repeat (nq) begin
      pick = $urandom_range(99);
      lvl  = $urandom_range(plan_levels);
      c[0] = $urandom_range((1 << lvl) - 1);
      c[1] = $urandom_range((1 << lvl) - 1);
      c[2] = $urandom_range((1 << lvl) - 1);
      if (pick >= 76 && pick < 86) begin
        // Push either one coordinate or the level past its bound.
        if (lvl < MAXL && $urandom_range(1)) begin
          axis    = $urandom_range(2);
          c[axis] = $urandom_range(1 << lvl, 31);
        end else begin
          lvl = $urandom_range(plan_levels + 1, 7);
        end
      end
      if (pick < 86) begin
        queue_req(REQ_QUERY, lvl, c[0], c[1], c[2], $urandom_range(1));
      end else if (pick < 93 || side == 32) begin
        queue_req(REQ_UNKNOWN, $urandom_range(7), $urandom_range(31), $urandom_range(31),
                  $urandom_range(31), $urandom_range(1));
      end else begin
        axis    = $urandom_range(2);
        c[axis] = $urandom_range(side, 31);
        queue_req(REQ_LOAD, $urandom_range(7), c[0], c[1], c[2], $urandom_range(1));
      end
    end
    // Sometimes end on an in-range load so the following queries see an unbuilt tree.
    if ($urandom_range(3) == 0) begin
      queue_req(REQ_LOAD, 0, $urandom_range(side - 1), $urandom_range(side - 1),
                $urandom_range(side - 1), $urandom_range(1));
      queue_req(REQ_QUERY, 0, 0, 0, 0, 0);
    end
  endtask

  // Hold until every request is taken and every reply is back, then let the pipe settle.
  task automatic wait_idle();
    while (req_backlog.size() != 0 || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid(input int value);
    @(negedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.grid_levels <= GRID_W'(value);
    do @(posedge clk); while (cfg_bus.valid !== 1'b1 || cfg_bus.ready !== 1'b1);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    plan_levels = (value > MAXL) ? MAXL : value;
  endtask

  // A phase: new register value, a query on the freshly cleared tree, then rounds.
  // Idle patterns rotate: none, sender idle, receiver stalling, both.
  task automatic run_phase(input int grid, input int rounds, input int nq);
    int r;
    wait_idle();
    write_grid(grid);
    case (phase_no % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
    phase_no++;
    queue_req(REQ_QUERY, $urandom_range(plan_levels), 0, 0, 0, $urandom_range(1));
    for (r = 0; r < rounds; r++)
      run_round(nq, plan_levels <= 2 || (r == 0 && plan_levels == 3));
    // Block the result side for a long stretch while the sender keeps pushing.
    if (grid == 4)
      long_stall_req++;
  endtask

  // Sender: present the oldest pending request at the falling edge and hold it until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_bus.valid       <= 1'b1;
        in_bus.req_type    <= req_backlog[0].req;
        in_bus.level       <= req_backlog[0].lvl;
        in_bus.coord_x     <= req_backlog[0].x;
        in_bus.coord_y     <= req_backlog[0].y;
        in_bus.coord_z     <= req_backlog[0].z;
        in_bus.voxel_solid <= req_backlog[0].solid;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver pacing, with a long hold-off counted here whenever one is requested.
  always @(negedge clk) begin : sink_pace
    int stall_served;
    int stall_left;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_served = long_stall_req;
      stall_left   = 0;
    end else begin
      if (long_stall_req != stall_served) begin
        stall_served = long_stall_req;
        stall_left   = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Rising edge: record every transaction, advance the shadow, check replies, and
  // watch for the block going quiet.
  always @(posedge clk) begin : accept_side
    bit          out_fire, cfg_fire;
    voxel_req_t  seen;
    node_reply_t want;
    in_fire  = rst_n && in_bus.valid === 1'b1 && in_bus.ready === 1'b1;
    out_fire = rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1;
    cfg_fire = rst_n && cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1;
    if (cfg_fire) begin
      grid_shadow = cfg_bus.grid_levels;
      tree_valid  = 1'b0;
    end
    if (in_fire) begin
      seen.req   = in_bus.req_type;
      seen.lvl   = in_bus.level;
      seen.x     = in_bus.coord_x;
      seen.y     = in_bus.coord_y;
      seen.z     = in_bus.coord_z;
      seen.solid = in_bus.voxel_solid;
      void'(req_backlog.pop_front());
      awaited_replies.push_back(apply_request(seen));
    end
    if (out_fire) begin
      if (awaited_replies.size() == 0) begin
        mismatch_count++;
        $error("result with no request outstanding: node_state %0d status %0d",
               out_bus.node_state, out_bus.status);
      end else begin
        want = awaited_replies.pop_front();
        if (out_bus.node_state !== want.state) begin
          mismatch_count++;
          $error("node_state mismatch: expected %0d, actual %0d", want.state,
                 out_bus.node_state);
        end
        if (out_bus.status !== want.status) begin
          mismatch_count++;
          $error("status mismatch: expected %0d, actual %0d", want.status, out_bus.status);
        end
      end
    end
    if (in_fire || out_fire || cfg_fire || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.req_type     = REQ_LOAD;
    in_bus.level        = '0;
    in_bus.coord_x      = '0;
    in_bus.coord_y      = '0;
    in_bus.coord_z      = '0;
    in_bus.voxel_solid  = 1'b0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.grid_levels = GRID_LEVELS_RST;
    plan_levels         = GRID_LEVELS_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Nothing built yet: leaf query with all-ones coordinates, root query, unknown request.
    queue_req(REQ_QUERY, 5, 31, 31, 31, 1);
    queue_req(REQ_QUERY, 0, 0, 0, 0, 0);
    queue_req(REQ_UNKNOWN, 7, 31, 31, 31, 1);
    wait_idle();

    // Single-voxel grid: rejected loads on each axis, build, root and range queries,
    // then a load that invalidates the tree and a rebuild.
    write_grid(0);
    queue_req(REQ_LOAD, 0, 0, 0, 0, 1);
    queue_req(REQ_LOAD, 0, 31, 31, 31, 0);
    queue_req(REQ_LOAD, 0, 1, 0, 0, 1);
    queue_req(REQ_LOAD, 0, 0, 16, 0, 1);
    queue_req(REQ_LOAD, 0, 0, 0, 8, 1);
    queue_req(REQ_BUILD, 0, 0, 0, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 0, 0, 0);
    queue_req(REQ_QUERY, 1, 0, 0, 0, 0);
    queue_req(REQ_QUERY, 7, 0, 0, 0, 0);
    queue_req(REQ_QUERY, 0, 1, 0, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 0, 31, 0);
    queue_req(REQ_LOAD, 0, 0, 0, 0, 0);
    queue_req(REQ_QUERY, 0, 0, 0, 0, 0);
    queue_req(REQ_BUILD, 7, 31, 31, 31, 1);
    queue_req(REQ_QUERY, 0, 0, 0, 0, 1);
    queue_req(REQ_UNKNOWN, 0, 0, 0, 0, 0);

    // Small grids get many builds; full depth is filled once and built a few times,
    // including with register values that saturate.
    run_phase(1, 3, 20);
    run_phase(2, 3, 20);
    run_phase(3, 3, 25);
    run_phase(0, 3, 10);
    run_phase(4, 1, 60);
    run_phase(5, 1, 70);
    run_phase(7, 1, 60);
    run_phase(2, 3, 20);
    run_phase(6, 1, 60);
    run_phase(3, 2, 25);
    run_phase(1, 3, 15);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
